/* rtl/icpf_pkg.sv */
// ----------------------------------------------------------------------------
// icpf_pkg
// Shared widths, payload types and helpers for the in-circle point filter.
// ----------------------------------------------------------------------------
package icpf_pkg;

  localparam int COORD_W   = 24;
  localparam int ID_W      = 24;

  // point-relative coordinate, its products, lifted terms and 2x2 minors
  localparam int DIFF_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int WIDE_W    = PROD_W + 1;

  // split of a wide operand for the 3x3 expansion products
  localparam int LO_W      = DIFF_W;
  localparam int HI_W      = WIDE_W - LO_W;
  localparam int HH_W      = 2 * HI_W;
  localparam int LL_W      = 2 * LO_W;
  localparam int HL_W      = HI_W + LO_W + 1;
  localparam int MID_W     = HL_W + 1;
  localparam int TERM_W    = HH_W + LL_W;
  localparam int DET_W     = TERM_W + 2;

  localparam int NUM_TERMS = 3;

  localparam int S_DATA_W  = ((ID_W + 8 * COORD_W + 7) / 8) * 8;
  localparam int M_DATA_W  = ((ID_W + 7) / 8) * 8;

  typedef struct packed {
    logic            present;
    logic [ID_W-1:0] id;
  } icpf_tag_t;

  typedef struct packed {
    icpf_tag_t                 tag;
    logic signed [WIDE_W-1:0]  la;
    logic signed [WIDE_W-1:0]  lb;
    logic signed [WIDE_W-1:0]  lc;
    logic signed [WIDE_W-1:0]  m1;
    logic signed [WIDE_W-1:0]  m2;
    logic signed [WIDE_W-1:0]  m3;
  } icpf_minor_t;

  typedef struct packed {
    logic            keep;
    logic [ID_W-1:0] id;
  } icpf_res_t;

  function automatic logic signed [DIFF_W-1:0] rel_coord(
    input logic [COORD_W-1:0] v,
    input logic [COORD_W-1:0] p
  );
    rel_coord = $signed({v[COORD_W-1], v}) - $signed({p[COORD_W-1], p});
  endfunction

  function automatic logic signed [WIDE_W-1:0] widen_prod(
    input logic [PROD_W-1:0] v
  );
    widen_prod = $signed({v[PROD_W-1], v});
  endfunction

endpackage

/* rtl/incircle_point_filter_top.sv */
// ----------------------------------------------------------------------------
// incircle_point_filter_top
// Delaunay in-circle test used as a point filter: exact integer determinant.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)                          tuser
//  s_axis   in   point_id, px, py, ax, ay, bx, by_coord,     point_present
//                cx, cy
//  m_axis   out  kept_id                                     keep
//
//  One transaction per cycle sustained while m_axis does not stall; 7
//  pipeline stages ahead of the output register, 12 25x25 multipliers up
//  front, 12 split partial multipliers for the 3x3 expansion.
//  Reset clears the stage valid bits and the output/skid flags only.
//  A stall on m_axis fills the skid entry; s_axis_tready then drops in
//  the next cycle and the whole pipeline holds until the skid drains.
// ----------------------------------------------------------------------------
module incircle_point_filter_top
  import icpf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_id, px, py, ax, ay, bx, by_coord, cx, cy
  input  logic [S_DATA_W-1:0]  s_axis_tdata,
  // point_present
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // kept_id
  output logic [M_DATA_W-1:0]  m_axis_tdata,
  // keep
  output logic [0:0]           m_axis_tuser
);

  localparam int PX_LSB = ID_W;

  logic        advance;
  icpf_tag_t   in_tag;
  logic        minor_valid;
  icpf_minor_t minor;
  logic        det_valid;
  icpf_res_t   det_res;
  icpf_res_t   out_res;

  assign s_axis_tready = advance;
  assign in_tag.present = s_axis_tuser[0];
  assign in_tag.id      = s_axis_tdata[ID_W-1:0];

  icpf_minor_stage u_minor (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (s_axis_tvalid),
    .in_tag    (in_tag),
    .px        (s_axis_tdata[PX_LSB + 0*COORD_W +: COORD_W]),
    .py        (s_axis_tdata[PX_LSB + 1*COORD_W +: COORD_W]),
    .ax        (s_axis_tdata[PX_LSB + 2*COORD_W +: COORD_W]),
    .ay        (s_axis_tdata[PX_LSB + 3*COORD_W +: COORD_W]),
    .bx        (s_axis_tdata[PX_LSB + 4*COORD_W +: COORD_W]),
    .by_coord  (s_axis_tdata[PX_LSB + 5*COORD_W +: COORD_W]),
    .cx        (s_axis_tdata[PX_LSB + 6*COORD_W +: COORD_W]),
    .cy        (s_axis_tdata[PX_LSB + 7*COORD_W +: COORD_W]),
    .out_valid (minor_valid),
    .out_minor (minor)
  );

  icpf_det_stage u_det (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .in_valid  (minor_valid),
    .in_minor  (minor),
    .out_valid (det_valid),
    .out_res   (det_res)
  );

  icpf_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (det_valid),
    .in_res    (det_res),
    .advance   (advance),
    .out_valid (m_axis_tvalid),
    .out_res   (out_res),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata    = M_DATA_W'(out_res.id);
  assign m_axis_tuser[0] = out_res.keep;

endmodule

/* rtl/icpf_minor_stage.sv */
// ----------------------------------------------------------------------------
// icpf_minor_stage
// Front three stages: point-relative coordinates, 25x25 products, then the
// lifted squared distances and the three 2x2 orientation minors.
// ----------------------------------------------------------------------------
module icpf_minor_stage
  import icpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  icpf_tag_t           in_tag,
  input  logic [COORD_W-1:0]  px,
  input  logic [COORD_W-1:0]  py,
  input  logic [COORD_W-1:0]  ax,
  input  logic [COORD_W-1:0]  ay,
  input  logic [COORD_W-1:0]  bx,
  input  logic [COORD_W-1:0]  by_coord,
  input  logic [COORD_W-1:0]  cx,
  input  logic [COORD_W-1:0]  cy,
  output logic                out_valid,
  output icpf_minor_t         out_minor
);

  logic v1, v2, v3;
  icpf_tag_t tag1, tag2, tag3;

  logic signed [DIFF_W-1:0] dax, day, dbx, dby, dcx, dcy;

  logic signed [PROD_W-1:0] sq_ax, sq_ay, sq_bx, sq_by, sq_cx, sq_cy;
  logic signed [PROD_W-1:0] cr_bc0, cr_bc1, cr_ac0, cr_ac1, cr_ab0, cr_ab1;

  logic signed [WIDE_W-1:0] la, lb, lc, m1, m2, m3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag1   <= in_tag;
      dax    <= rel_coord(ax, px);
      day    <= rel_coord(ay, py);
      dbx    <= rel_coord(bx, px);
      dby    <= rel_coord(by_coord, py);
      dcx    <= rel_coord(cx, px);
      dcy    <= rel_coord(cy, py);

      tag2   <= tag1;
      sq_ax  <= dax * dax;
      sq_ay  <= day * day;
      sq_bx  <= dbx * dbx;
      sq_by  <= dby * dby;
      sq_cx  <= dcx * dcx;
      sq_cy  <= dcy * dcy;
      cr_bc0 <= dbx * dcy;
      cr_bc1 <= dcx * dby;
      cr_ac0 <= dax * dcy;
      cr_ac1 <= dcx * day;
      cr_ab0 <= dax * dby;
      cr_ab1 <= dbx * day;

      tag3   <= tag2;
      la     <= widen_prod(sq_ax) + widen_prod(sq_ay);
      lb     <= widen_prod(sq_bx) + widen_prod(sq_by);
      lc     <= widen_prod(sq_cx) + widen_prod(sq_cy);
      m1     <= widen_prod(cr_bc0) - widen_prod(cr_bc1);
      m2     <= widen_prod(cr_ac0) - widen_prod(cr_ac1);
      m3     <= widen_prod(cr_ab0) - widen_prod(cr_ab1);
    end
  end

  assign out_valid     = v3;
  assign out_minor.tag = tag3;
  assign out_minor.la  = la;
  assign out_minor.lb  = lb;
  assign out_minor.lc  = lc;
  assign out_minor.m1  = m1;
  assign out_minor.m2  = m2;
  assign out_minor.m3  = m3;

endmodule

/* rtl/icpf_det_stage.sv */
// ----------------------------------------------------------------------------
// icpf_det_stage
// Back four stages: lift*minor products split into four partial products,
// partial sums, full-width terms, then the signed determinant and its test.
// ----------------------------------------------------------------------------
module icpf_det_stage
  import icpf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         in_valid,
  input  icpf_minor_t  in_minor,
  output logic         out_valid,
  output icpf_res_t    out_res
);

  logic v4, v5, v6, v7;
  icpf_tag_t tag4, tag5, tag6, tag7;

  logic signed [WIDE_W-1:0] lift [NUM_TERMS];
  logic signed [WIDE_W-1:0] minr [NUM_TERMS];
  logic signed [HI_W-1:0]   l_hi [NUM_TERMS];
  logic signed [HI_W-1:0]   m_hi [NUM_TERMS];
  logic [LO_W-1:0]          l_lo [NUM_TERMS];
  logic [LO_W-1:0]          m_lo [NUM_TERMS];

  logic signed [HH_W-1:0]   hh4 [NUM_TERMS];
  logic signed [HL_W-1:0]   hl4 [NUM_TERMS];
  logic signed [HL_W-1:0]   lh4 [NUM_TERMS];
  logic [LL_W-1:0]          ll4 [NUM_TERMS];

  logic signed [HH_W-1:0]   hh5  [NUM_TERMS];
  logic [LL_W-1:0]          ll5  [NUM_TERMS];
  logic signed [MID_W-1:0]  mid5 [NUM_TERMS];

  logic signed [TERM_W-1:0] term6 [NUM_TERMS];
  logic signed [DET_W-1:0]  det7;

  assign lift[0] = in_minor.la;
  assign lift[1] = in_minor.lb;
  assign lift[2] = in_minor.lc;
  assign minr[0] = in_minor.m1;
  assign minr[1] = in_minor.m2;
  assign minr[2] = in_minor.m3;

  // v = hi * 2^LO_W + lo, hi signed, lo unsigned
  always_comb begin
    for (int i = 0; i < NUM_TERMS; i++) begin
      l_hi[i] = lift[i][WIDE_W-1:LO_W];
      m_hi[i] = minr[i][WIDE_W-1:LO_W];
      l_lo[i] = lift[i][LO_W-1:0];
      m_lo[i] = minr[i][LO_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v4 <= in_valid;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag4 <= in_minor.tag;
      tag5 <= tag4;
      tag6 <= tag5;
      tag7 <= tag6;
      for (int i = 0; i < NUM_TERMS; i++) begin
        hh4[i]   <= l_hi[i] * m_hi[i];
        hl4[i]   <= l_hi[i] * $signed({1'b0, m_lo[i]});
        lh4[i]   <= $signed({1'b0, l_lo[i]}) * m_hi[i];
        ll4[i]   <= l_lo[i] * m_lo[i];

        hh5[i]   <= hh4[i];
        ll5[i]   <= ll4[i];
        mid5[i]  <= MID_W'(hl4[i]) + MID_W'(lh4[i]);

        // ll < 2^LL_W, so the outer partials just concatenate
        term6[i] <= $signed({hh5[i], ll5[i]}) + (TERM_W'(mid5[i]) <<< LO_W);
      end
      det7 <= DET_W'(term6[0]) - DET_W'(term6[1]) + DET_W'(term6[2]);
    end
  end

  assign out_valid    = v7;
  assign out_res.keep = tag7.present && !det7[DET_W-1] && (|det7);
  assign out_res.id   = out_res.keep ? tag7.id : '0;

endmodule

/* rtl/icpf_out_skid.sv */
// ----------------------------------------------------------------------------
// icpf_out_skid
// Output register plus one skid entry; the pipeline advance is registered.
// ----------------------------------------------------------------------------
module icpf_out_skid
  import icpf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  icpf_res_t  in_res,
  output logic       advance,
  output logic       out_valid,
  output icpf_res_t  out_res,
  input  logic       out_ready
);

  logic      skid_full;
  icpf_res_t skid_res;
  logic      push;
  logic      pop;

  assign advance = !skid_full;
  assign push    = in_valid && advance;
  assign pop     = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (pop) begin
        skid_full <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_full <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_res <= in_res;
      end else begin
        out_res <= in_res;
      end
    end
  end

endmodule

/* rtl/icpf_checker.sv */
// ----------------------------------------------------------------------------
// icpf_checker
// Port-level checks for the in-circle point filter, bound to the top level.
// ----------------------------------------------------------------------------
module icpf_checker
  import icpf_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_DATA_W-1:0]  m_axis_tdata,
  input logic [0:0]           m_axis_tuser
);

  // rejected points carry a zero id
  a_drop_zero_id: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0)
    else $error("dropped point carries nonzero id");

  // input side only backs up behind a stalled output
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input not ready without an output stall");

  a_ready_output: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input not ready while output empty");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("output not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transaction withdrawn");

endmodule

bind incircle_point_filter_top icpf_checker u_icpf_checker (.*);
